// ===== hw/rtl/gfm_pkg.sv =====
// Shared widths, register map and reset values for the gaze fixation mean filter.
`timescale 1ns / 1ps
package gfm_pkg;

  // Field widths
  localparam int X_W      = 14;  // gaze_x / gaze_y
  localparam int T_W      = 32;  // timestamps
  localparam int MEAN_W   = 18;  // mean_x / mean_y, 4 fractional bits
  localparam int CNT_W    = 7;   // used_count
  localparam int RAD_W    = 12;  // fixation_radius
  localparam int FRAC_W   = 4;

  // Window depth default
  localparam int WINDOW_DEF = 64;

  // Configuration port
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 2;
  localparam logic [PADDR_W-1:0] REG_FIXATION_RADIUS = 2'd0;
  localparam logic [RAD_W-1:0]   RADIUS_RESET        = 12'd40;

endpackage

// ===== hw/rtl/gfm_if.sv =====
// Valid/ready channel interfaces for gaze samples and filtered results.
`timescale 1ns / 1ps
interface gfm_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [gfm_pkg::X_W-1:0]   gaze_x;
  logic signed [gfm_pkg::X_W-1:0]   gaze_y;
  logic        [gfm_pkg::T_W-1:0]   sample_time_ms;
  logic        [gfm_pkg::T_W-1:0]   now_ms;

  modport source (output valid, gaze_x, gaze_y, sample_time_ms, now_ms, input ready);
  modport sink   (input valid, gaze_x, gaze_y, sample_time_ms, now_ms, output ready);
endinterface

interface gfm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gfm_pkg::MEAN_W-1:0] mean_x;
  logic signed [gfm_pkg::MEAN_W-1:0] mean_y;
  logic        [gfm_pkg::CNT_W-1:0]  used_count;
  logic        [gfm_pkg::T_W-1:0]    fixation_ms;

  modport source (output valid, mean_x, mean_y, used_count, fixation_ms, input ready);
  modport sink   (input valid, mean_x, mean_y, used_count, fixation_ms, output ready);
endinterface

// ===== hw/rtl/gfm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/gfm_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module gfm_div #(
  parameter int DVD_W = 24,
  parameter int DSR_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DSR_W-1:0] rem_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVD_W-1:0] quot_r;

  logic [DSR_W:0]   rem_sh;
  logic             fits;
  logic [DSR_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    fits    = (rem_sh >= {1'b0, divisor});
    rem_nxt = fits ? DSR_W'(rem_sh - {1'b0, divisor}) : rem_sh[DSR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      dvd_r  <= dividend;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
      quot_r <= {quot_r[DVD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

// ===== hw/rtl/gaze_fixation_mean_filter.sv =====
// Top level: gaze sample window, fixation walk sequencer and result register.
// Sequence: accept a sample, walk each older window entry through READ, MNX,
//   MNY, DX, DY, NR, RR and CMP on the shared multiplier, then form both
//   means on the serial divider and load the result register.
// A new sample is accepted only in S_IDLE, after the previous result is loaded.
// Reset (rst_n low, synchronous): empty window, write slot 0, radius 40.
`timescale 1ns / 1ps
module gaze_fixation_mean_filter #(
  parameter int WINDOW = gfm_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // APB-style configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gfm_pkg::PADDR_W-1:0] paddr,
  input  logic [gfm_pkg::PDATA_W-1:0] pwdata,
  output logic [gfm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // Channels
  gfm_in_if.sink                      in_chan,
  gfm_out_if.source                   out_chan
);

  localparam int X_W    = gfm_pkg::X_W;
  localparam int T_W    = gfm_pkg::T_W;
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int NW     = $clog2(WINDOW + 1);            // holds 0..WINDOW
  localparam int SUM_W  = X_W + $clog2(WINDOW);          // signed running sum
  localparam int MUL_W  = SUM_W + 1;                     // shared multiplier operand
  localparam int PROD_W = 2 * MUL_W;
  localparam int DVD_W  = SUM_W + gfm_pkg::FRAC_W;       // |sum| * 16 + n/2
  localparam int ENT_W  = 2 * X_W + T_W;

  // One-hot sequencer states
  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_READ = 14'b00000000000010,  // read next older entry
    S_MNX  = 14'b00000000000100,  // n * x
    S_MNY  = 14'b00000000001000,  // n * y, form dx
    S_DX   = 14'b00000000010000,  // dx^2, form dy
    S_DY   = 14'b00000000100000,  // dy^2, capture dx^2
    S_NR   = 14'b00000001000000,  // n * radius, add dy^2
    S_RR   = 14'b00000010000000,  // (n * radius)^2
    S_CMP  = 14'b00000100000000,  // distance test
    S_DXS  = 14'b00001000000000,  // start mean_x division
    S_DXW  = 14'b00010000000000,
    S_DYS  = 14'b00100000000000,  // start mean_y division
    S_DYW  = 14'b01000000000000,
    S_OUT  = 14'b10000000000000   // wait for result register
  } state_t;

  state_t state_r, state_nxt;

  // Control state
  logic [IDX_W-1:0]         slot_r, slot_nxt;
  logic [NW-1:0]            fill_r, fill_nxt;
  logic [gfm_pkg::RAD_W-1:0] radius_r;
  logic                     out_valid_r, out_valid_nxt;

  // Walk datapath
  logic [IDX_W-1:0]         idx_r;
  logic [NW-1:0]            rem_r;
  logic [NW-1:0]            n_r;
  logic signed [SUM_W-1:0]  sx_r, sy_r;
  logic [T_W-1:0]           oldest_r, now_r;
  logic signed [PROD_W-1:0] p_r;
  logic signed [MUL_W-1:0]  dx_r, dy_r;
  logic signed [PROD_W:0]   d2_r;
  logic signed [gfm_pkg::MEAN_W-1:0] qx_r, qy_r;

  // Output register
  logic signed [gfm_pkg::MEAN_W-1:0] mx_r, my_r;
  logic [gfm_pkg::CNT_W-1:0] cnt_out_r;
  logic [T_W-1:0]            fix_r;

  logic in_xfer, out_xfer, load_out, cfg_wr;
  assign in_xfer = in_chan.valid && (state_r == S_IDLE);
  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);
  assign out_xfer = out_valid_r && out_chan.ready;

  // ---------------- configuration ----------------
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr == gfm_pkg::REG_FIXATION_RADIUS)
                  ? gfm_pkg::PDATA_W'(radius_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= gfm_pkg::RADIUS_RESET;
    end else if (cfg_wr && paddr == gfm_pkg::REG_FIXATION_RADIUS) begin
      radius_r <= pwdata[gfm_pkg::RAD_W-1:0];
    end
  end

  // ---------------- sample window ----------------
  logic [ENT_W-1:0]        rdata;
  logic signed [X_W-1:0]   ent_x, ent_y;
  logic [T_W-1:0]          ent_t;

  gfm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (slot_r),
    .wdata ({in_chan.gaze_x, in_chan.gaze_y, in_chan.sample_time_ms}),
    .re    (state_r == S_READ),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign ent_x = rdata[ENT_W-1 -: X_W];
  assign ent_y = rdata[T_W +: X_W];
  assign ent_t = rdata[T_W-1:0];

  // ---------------- shared multiplier ----------------
  logic signed [MUL_W-1:0] mul_a, mul_b, n_op;
  assign n_op = MUL_W'($signed({1'b0, n_r}));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MNX: begin
        mul_a = n_op;
        mul_b = MUL_W'(ent_x);
      end
      S_MNY: begin
        mul_a = n_op;
        mul_b = MUL_W'(ent_y);
      end
      S_DX: begin
        mul_a = dx_r;
        mul_b = dx_r;
      end
      S_DY: begin
        mul_a = dy_r;
        mul_b = dy_r;
      end
      S_NR: begin
        mul_a = n_op;
        mul_b = MUL_W'($signed({1'b0, radius_r}));
      end
      S_RR: begin
        mul_a = p_r[MUL_W-1:0];
        mul_b = p_r[MUL_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
  end

  // ---------------- divider ----------------
  logic                 div_start, div_done, div_neg;
  logic [SUM_W-1:0]     div_mag;
  logic [DVD_W-1:0]     div_dvd, div_q;
  logic signed [SUM_W-1:0] div_sum;
  logic signed [gfm_pkg::MEAN_W-1:0] mean_nxt;

  assign div_start = (state_r == S_DXS) || (state_r == S_DYS);
  assign div_sum   = ((state_r == S_DXS) || (state_r == S_DXW)) ? sx_r : sy_r;
  assign div_neg   = div_sum[SUM_W-1];
  assign div_mag   = div_neg ? SUM_W'(-div_sum) : SUM_W'(div_sum);
  // round half away from zero on the magnitude
  assign div_dvd   = DVD_W'({div_mag, {gfm_pkg::FRAC_W{1'b0}}}) + DVD_W'(n_r >> 1);
  assign mean_nxt  = div_neg ? gfm_pkg::MEAN_W'(-div_q) : gfm_pkg::MEAN_W'(div_q);

  gfm_div #(
    .DVD_W (DVD_W),
    .DSR_W (NW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------- sequencer ----------------
  logic stop;
  assign stop = d2_r > (PROD_W+1)'(p_r);

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          slot_nxt = (slot_r == IDX_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
          fill_nxt = (fill_r == NW'(WINDOW)) ? fill_r : fill_r + 1'b1;
          // newest sample is always taken; walk older ones if any
          state_nxt = (fill_r == '0) ? S_DXS : S_READ;
        end
      end
      S_READ: state_nxt = S_MNX;
      S_MNX:  state_nxt = S_MNY;
      S_MNY:  state_nxt = S_DX;
      S_DX:   state_nxt = S_DY;
      S_DY:   state_nxt = S_NR;
      S_NR:   state_nxt = S_RR;
      S_RR:   state_nxt = S_CMP;
      S_CMP: begin
        if (stop || rem_r == NW'(1)) begin
          state_nxt = S_DXS;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_DXS:  state_nxt = S_DXW;
      S_DXW:  state_nxt = div_done ? S_DYS : S_DXW;
      S_DYS:  state_nxt = S_DYW;
      S_DYW:  state_nxt = div_done ? S_OUT : S_DYW;
      S_OUT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Walk datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          idx_r    <= (slot_r == '0) ? IDX_W'(WINDOW - 1) : slot_r - 1'b1;
          // older entries still to examine; a full window just lost its oldest
          rem_r    <= (fill_r == NW'(WINDOW)) ? NW'(WINDOW - 1) : fill_r;
          n_r      <= NW'(1);
          sx_r     <= SUM_W'(in_chan.gaze_x);
          sy_r     <= SUM_W'(in_chan.gaze_y);
          oldest_r <= in_chan.sample_time_ms;
          now_r    <= in_chan.now_ms;
        end
      end
      S_MNY: dx_r <= MUL_W'(p_r - PROD_W'(sx_r));
      S_DX:  dy_r <= MUL_W'(p_r - PROD_W'(sy_r));
      S_DY:  d2_r <= (PROD_W+1)'(p_r);
      S_NR:  d2_r <= d2_r + (PROD_W+1)'(p_r);
      S_CMP: begin
        if (!stop) begin
          sx_r     <= sx_r + SUM_W'(ent_x);
          sy_r     <= sy_r + SUM_W'(ent_y);
          n_r      <= n_r + 1'b1;
          oldest_r <= ent_t;
          rem_r    <= rem_r - 1'b1;
          idx_r    <= (idx_r == '0) ? IDX_W'(WINDOW - 1) : idx_r - 1'b1;
        end
      end
      S_DXW: begin
        if (div_done) begin
          qx_r <= mean_nxt;
        end
      end
      S_OUT: begin
        if (load_out) begin
          mx_r      <= qx_r;
          my_r      <= qy_r;
          cnt_out_r <= gfm_pkg::CNT_W'(n_r);
          fix_r     <= (now_r >= oldest_r) ? now_r - oldest_r : '0;
        end
      end
      S_DYW: begin
        if (div_done) begin
          qy_r <= mean_nxt;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- channel ports ----------------
  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.mean_x     = mx_r;
  assign out_chan.mean_y     = my_r;
  assign out_chan.used_count = cnt_out_r;
  assign out_chan.fixation_ms = fix_r;

endmodule

// ===== hw/rtl/gfm_checker.sv =====
// Port-level checks for the gaze fixation mean filter, bound to the top level.
`timescale 1ns / 1ps
module gfm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gfm_pkg::CNT_W-1:0]   used_count
);

  // A result stays offered until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // The block is busy right after taking a sample
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a sample transfer");

  // At least the newest sample is always used
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> used_count != '0)
    else $error("result with zero used samples");

  // Nothing is offered straight out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind gaze_fixation_mean_filter gfm_checker u_gfm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .used_count (out_chan.used_count)
);

// ===== dv/tb_gaze_fixation_mean_filter.sv =====
// Testbench for gaze_fixation_mean_filter: directed table, random fixation bursts, scoreboard.
`timescale 1ns / 1ps
module tb_gaze_fixation_mean_filter;

  localparam int X_W             = gfm_pkg::X_W;
  localparam int T_W             = gfm_pkg::T_W;
  localparam int MEAN_W          = gfm_pkg::MEAN_W;
  localparam int CNT_W           = gfm_pkg::CNT_W;
  localparam int RAD_W           = gfm_pkg::RAD_W;
  localparam int PADDR_W         = gfm_pkg::PADDR_W;
  localparam int PDATA_W         = gfm_pkg::PDATA_W;
  localparam logic [PADDR_W-1:0] REG_FIXATION_RADIUS = gfm_pkg::REG_FIXATION_RADIUS;
  localparam logic [RAD_W-1:0]   RADIUS_RESET        = gfm_pkg::RADIUS_RESET;

  localparam int WINDOW          = gfm_pkg::WINDOW_DEF;
  localparam int PX_MAX          = 2 ** (X_W - 1) - 1;
  localparam int PX_MIN          = -(2 ** (X_W - 1));
  // Settling margin for the worst case walk, which covers a full window.
  localparam int SETTLE_CYCLES   = 800;
  localparam int CYCLE_LIMIT     = 1_000_000;
  // Long receiver hold-off: the block fills up and must stall its input.
  localparam int PRESSURE_AT     = 300;
  localparam int PRESSURE_CYCLES = 1500;
  localparam int SEG_ITEMS       = 64;

  typedef struct {
    logic signed [X_W-1:0] gaze_x;
    logic signed [X_W-1:0] gaze_y;
    logic [T_W-1:0]        sample_time_ms;
    logic [T_W-1:0]        now_ms;
  } gaze_sample_t;

  typedef struct {
    logic signed [MEAN_W-1:0] mean_x;
    logic signed [MEAN_W-1:0] mean_y;
    logic [CNT_W-1:0]         used_count;
    logic [T_W-1:0]           fixation_ms;
  } fix_result_t;

  // A transfer either carries a hand-typed expectation or defers to the predictor.
  typedef struct {
    bit          pinned;
    fix_result_t res;
  } pin_t;

  typedef enum logic {ROW_SAMPLE, ROW_RADIUS} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    gaze_sample_t smp;
    bit           pinned;
    fix_result_t  res;
    logic [31:0]  radius;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  gfm_in_if  sample_bus ();
  gfm_out_if result_bus ();

  gaze_fixation_mean_filter #(.WINDOW(WINDOW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_chan  (sample_bus),
    .out_chan (result_bus)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the sample ring and the radius register.
  // ---------------------------------------------------------------------------
  logic signed [X_W-1:0] win_x [WINDOW];
  logic signed [X_W-1:0] win_y [WINDOW];
  logic [T_W-1:0]        win_t [WINDOW];
  int unsigned           wr_slot;
  int unsigned           fill;
  logic [RAD_W-1:0]      radius_cfg;

  fix_result_t awaited_results [$];
  pin_t        pinned_q [$];

  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;

  // Random burst generator state
  int          cx;
  int          cy;
  int          dwell_left;
  logic [31:0] clock_ms;

  plan_row_t directed_plan [$];

  // Q4 mean, rounded to nearest with ties away from zero.
  function automatic logic signed [MEAN_W-1:0] mean_q4(input longint sum, input longint n);
    longint mag;
    longint q;
    mag = (sum < 0) ? -sum : sum;
    q = (mag * 16 + n / 2) / n;
    q = (sum < 0) ? -q : q;
    return q[MEAN_W-1:0];
  endfunction

  // Push one sample into the ring and walk newest to oldest while each
  // candidate stays within the radius of the running mean (exact, squared).
  function automatic fix_result_t advance_filter(input gaze_sample_t s);
    int unsigned slot;
    int unsigned idx;
    int unsigned k;
    longint      sx, sy, n, x, y, dx, dy, d2, rn;
    logic [T_W-1:0] oldest;
    bit          stop;
    fix_result_t r;
    slot = wr_slot;
    win_x[slot] = s.gaze_x;
    win_y[slot] = s.gaze_y;
    win_t[slot] = s.sample_time_ms;
    wr_slot = (slot + 1) % WINDOW;
    if (fill < WINDOW) fill++;
    sx = 0;
    sy = 0;
    n = 0;
    oldest = '0;
    idx = slot;
    k = 0;
    stop = 0;
    while (k < fill && !stop) begin
      x = win_x[idx];
      y = win_y[idx];
      if (n > 0) begin
        dx = n * x - sx;
        dy = n * y - sy;
        d2 = dx * dx + dy * dy;
        rn = n * longint'(radius_cfg);
        if (d2 > rn * rn) stop = 1;
      end
      if (!stop) begin
        sx += x;
        sy += y;
        n++;
        oldest = win_t[idx];
        idx = (idx + WINDOW - 1) % WINDOW;
        k++;
      end
    end
    r.mean_x = mean_q4(sx, n);
    r.mean_y = mean_q4(sy, n);
    r.used_count = n[CNT_W-1:0];
    r.fixation_ms = (s.now_ms >= oldest) ? s.now_ms - oldest : '0;
    return r;
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic logic signed [X_W-1:0] clamp_px(input int v);
    if (v > PX_MAX) v = PX_MAX;
    else if (v < PX_MIN) v = PX_MIN;
    return v[X_W-1:0];
  endfunction

  // Directed table rows
  function automatic plan_row_t sample_row(input int x, input int y,
                                           input logic [31:0] t, input logic [31:0] now);
    plan_row_t row;
    row = '{kind: ROW_SAMPLE, default: '0};
    row.smp.gaze_x = x[X_W-1:0];
    row.smp.gaze_y = y[X_W-1:0];
    row.smp.sample_time_ms = t;
    row.smp.now_ms = now;
    return row;
  endfunction

  function automatic plan_row_t pinned_row(input int x, input int y,
                                           input logic [31:0] t, input logic [31:0] now,
                                           input int mx, input int my, input int cnt,
                                           input logic [31:0] fix);
    plan_row_t row;
    row = sample_row(x, y, t, now);
    row.pinned = 1;
    row.res.mean_x = mx[MEAN_W-1:0];
    row.res.mean_y = my[MEAN_W-1:0];
    row.res.used_count = cnt[CNT_W-1:0];
    row.res.fixation_ms = fix;
    return row;
  endfunction

  function automatic plan_row_t radius_row(input logic [31:0] value);
    plan_row_t row;
    row = '{kind: ROW_RADIUS, default: '0};
    row.radius = value;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, and a cycle counter that ends a hung run.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_gaze_fixation_mean_filter failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration port: write, then read back through the same port.
  // ---------------------------------------------------------------------------
  task automatic read_radius(output logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_FIXATION_RADIUS;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_radius(input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_FIXATION_RADIUS;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // register took the write at this edge; only the low RAD_W bits are kept
    radius_cfg = value[RAD_W-1:0];
    read_radius(readback);
    if (readback !== PDATA_W'(radius_cfg))
      flag_mismatch($sformatf("radius readback: expected %0d, got %0d", radius_cfg, readback));
  endtask

  // ---------------------------------------------------------------------------
  // Sample sender. Valid stays high from one transfer to the next unless an
  // idle cycle falls in between, so it is never dropped and raised in one step.
  // ---------------------------------------------------------------------------
  task automatic offer_sample(input gaze_sample_t s, input bit pinned, input fix_result_t pin_res);
    pin_t p;
    while ($urandom_range(99) < src_idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk);
    end
    p.pinned = pinned;
    p.res = pin_res;
    pinned_q.push_back(p);
    sample_bus.valid          <= 1'b1;
    sample_bus.gaze_x         <= s.gaze_x;
    sample_bus.gaze_y         <= s.gaze_y;
    sample_bus.sample_time_ms <= s.sample_time_ms;
    sample_bus.now_ms         <= s.now_ms;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every accepted sample has produced its result.
  // Each sample yields exactly one result, so the block is idle at that point.
  task automatic quiesce();
    sample_bus.valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
  endtask

  // Random part: mostly fixation bursts around a center with jitter scaled to
  // the radius, so walks go deep; some saccades and some full-range noise.
  task automatic run_fixations(input int count);
    gaze_sample_t s;
    fix_result_t  none;
    int           i;
    int           spread;
    none = '{default: '0};
    for (i = 0; i < count; i++) begin
      if (dwell_left == 0) begin
        dwell_left = ($urandom_range(9) == 0) ? $urandom_range(64, 90) : $urandom_range(1, 24);
        if ($urandom_range(9) == 0) begin
          cx = $urandom_range(1) ? PX_MAX : PX_MIN;
          cy = $urandom_range(1) ? PX_MAX : PX_MIN;
        end else begin
          cx = int'($urandom_range(16383)) + PX_MIN;
          cy = int'($urandom_range(16383)) + PX_MIN;
        end
      end
      dwell_left--;
      if ($urandom_range(99) < 12) begin
        s.gaze_x = X_W'($urandom_range(16383));
        s.gaze_y = X_W'($urandom_range(16383));
        s.sample_time_ms = $urandom;
        s.now_ms = $urandom;
      end else begin
        spread = ($urandom_range(7) == 0) ? 2 * radius_cfg + 1 : radius_cfg / 2;
        s.gaze_x = clamp_px(cx + int'($urandom_range(2 * spread)) - spread);
        s.gaze_y = clamp_px(cy + int'($urandom_range(2 * spread)) - spread);
        clock_ms += $urandom_range(1, 20);
        s.sample_time_ms = clock_ms;
        // now occasionally lags the sample timestamp: duration clamps to zero
        s.now_ms = ($urandom_range(9) == 0) ? clock_ms - $urandom_range(1, 50)
                                            : clock_ms + $urandom_range(0, 40);
      end
      offer_sample(s, 1'b0, none);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: random back-pressure, plus one long hold-off.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && results_seen >= PRESSURE_AT) begin
        hold_done = 1;
        hold_left = PRESSURE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= rst_n && ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard. Results are checked before the same edge's input transfer is
  // predicted; a result can never belong to a sample accepted at that edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    fix_result_t  want;
    fix_result_t  got;
    gaze_sample_t s;
    pin_t         p;
    if (rst_n) begin
      if (result_bus.valid && result_bus.ready) begin
        got.mean_x      = result_bus.mean_x;
        got.mean_y      = result_bus.mean_y;
        got.used_count  = result_bus.used_count;
        got.fixation_ms = result_bus.fixation_ms;
        if (awaited_results.size() == 0) begin
          flag_mismatch($sformatf("result %0d with nothing awaited: x=%0d y=%0d n=%0d ms=%0d",
                                  results_seen, got.mean_x, got.mean_y, got.used_count,
                                  got.fixation_ms));
        end else begin
          want = awaited_results.pop_front();
          if (got.mean_x !== want.mean_x || got.mean_y !== want.mean_y ||
              got.used_count !== want.used_count || got.fixation_ms !== want.fixation_ms)
            flag_mismatch($sformatf({"result %0d: expected x=%0d y=%0d n=%0d ms=%0d,",
                                     " got x=%0d y=%0d n=%0d ms=%0d"},
                                    results_seen, want.mean_x, want.mean_y, want.used_count,
                                    want.fixation_ms, got.mean_x, got.mean_y,
                                    got.used_count, got.fixation_ms));
        end
        results_seen++;
      end
      if (sample_bus.valid && sample_bus.ready) begin
        s.gaze_x         = sample_bus.gaze_x;
        s.gaze_y         = sample_bus.gaze_y;
        s.sample_time_ms = sample_bus.sample_time_ms;
        s.now_ms         = sample_bus.now_ms;
        p = pinned_q.pop_front();
        want = advance_filter(s);
        awaited_results.push_back(p.pinned ? p.res : want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    logic [PDATA_W-1:0] rb;
    logic [31:0]        seg_radius [6];
    int                 p;
    int                 seg;
    int                 unsigned idle_src [3];
    int                 unsigned idle_sink [3];

    rst_n   <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    sample_bus.valid          <= 1'b0;
    sample_bus.gaze_x         <= '0;
    sample_bus.gaze_y         <= '0;
    sample_bus.sample_time_ms <= '0;
    sample_bus.now_ms         <= '0;
    wr_slot = 0;
    fill = 0;
    radius_cfg = RADIUS_RESET;
    items_sent = 0;
    results_seen = 0;
    mismatches = 0;
    cycle_count = 0;
    dwell_left = 0;
    cx = 0;
    cy = 0;
    clock_ms = $urandom;
    idle_src  = '{29, 86, 0};
    idle_sink = '{86, 29, 0};
    src_idle_pct = idle_src[0];
    sink_idle_pct = idle_sink[0];

    // Directed part, radius at its reset value and an empty window.
    directed_plan.push_back(pinned_row(8191, -8192, 100, 1100, 131056, -131072, 1, 1000));
    // timestamp later than now: duration clamps to zero
    directed_plan.push_back(pinned_row(-8192, 8191, 2000, 1000, -131072, 131056, 1, 0));
    directed_plan.push_back(pinned_row(0, 0, 0, 0, 0, 0, 1, 0));
    directed_plan.push_back(pinned_row(0, 0, 0, 32'hFFFF_FFFF, 0, 0, 2, 32'hFFFF_FFFF));
    // exactly on the radius is still inside, one pixel more is out
    directed_plan.push_back(sample_row(40, 0, 10, 20));
    directed_plan.push_back(sample_row(41, 0, 11, 30));
    directed_plan.push_back(sample_row(24, 32, 12, 40));
    directed_plan.push_back(sample_row(-3, 5, 13, 50));
    // zero radius: only identical points chain together
    directed_plan.push_back(radius_row(32'd0));
    directed_plan.push_back(sample_row(7, 7, 20, 20));
    directed_plan.push_back(sample_row(7, 7, 21, 25));
    directed_plan.push_back(sample_row(8, 7, 22, 30));
    // upper data bits are dropped, leaving the widest radius
    directed_plan.push_back(radius_row(32'hFFFF_FFFF));
    directed_plan.push_back(sample_row(4095, 0, 30, 40));
    directed_plan.push_back(sample_row(-4095, 0, 31, 41));
    directed_plan.push_back(sample_row(8191, 8191, 32, 32));
    directed_plan.push_back(sample_row(-8192, -8192, 33, 0));
    // small cluster, means land on fractional and half-way values
    directed_plan.push_back(radius_row(32'd40));
    directed_plan.push_back(sample_row(100, 100, 40, 45));
    directed_plan.push_back(sample_row(101, 99, 41, 46));
    directed_plan.push_back(sample_row(99, 101, 42, 47));
    directed_plan.push_back(sample_row(100, 102, 43, 48));
    directed_plan.push_back(sample_row(98, 100, 44, 49));
    directed_plan.push_back(sample_row(-1, -2, 45, 50));
    directed_plan.push_back(sample_row(-2, -1, 46, 51));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    read_radius(rb);
    if (rb !== PDATA_W'(RADIUS_RESET))
      flag_mismatch($sformatf("radius after reset: expected %0d, got %0d", RADIUS_RESET, rb));

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_RADIUS) begin
        quiesce();
        write_radius(directed_plan[i].radius);
      end else begin
        offer_sample(directed_plan[i].smp, directed_plan[i].pinned, directed_plan[i].res);
      end
    end

    // Random part: three idling regimes, two radius settings each.
    seg_radius = '{32'd4095, $urandom_range(1, 60), 32'd0, $urandom_range(60, 400),
                   $urandom_range(0, 4095), 32'd40};
    for (p = 0; p < 3; p++) begin
      src_idle_pct = idle_src[p];
      sink_idle_pct = idle_sink[p];
      for (seg = 0; seg < 2; seg++) begin
        quiesce();
        write_radius(seg_radius[2 * p + seg]);
        run_fixations(SEG_ITEMS);
      end
    end

    quiesce();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb_gaze_fixation_mean_filter passed");
    end else begin
      $display("tb_gaze_fixation_mean_filter failed");
    end
    $finish;
  end

endmodule
